/* src/position_hold_cascade_pid_macros.svh */
// assertion helpers shared by the checker
`ifndef POSITION_HOLD_CASCADE_PID_MACROS_SVH
`define POSITION_HOLD_CASCADE_PID_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define PCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcp check failed");

// next-cycle implication, masked while reset is asserted
`define PCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcp check failed");

// next-cycle implication that also holds through reset
`define PCP_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pcp check failed");

`endif

/* src/pcp_pkg.sv */
`default_nettype none

package pcp_pkg;

    // defaults for the top level parameters
    localparam int AXES_DEF = 2;
    localparam int FRAC_DEF = 16;

    // field widths
    localparam int E_W    = 24;
    localparam int SPD_W  = 16;
    localparam int MS_W   = 8;
    localparam int GAIN_W = 8;
    localparam int LIM_W  = 16;
    localparam int BANK_W = 14;
    localparam int TILT_W = 15;
    localparam int FD_W   = 40;
    localparam int MB_W   = 24;
    localparam int DEN_W  = 22;
    localparam int P_W    = FD_W + MB_W;

    // apb port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // arithmetic constants
    localparam int K_TGT_DIV  = 100;
    localparam int K_OI_DIV   = 1000000;
    localparam int K_PT_DIV   = 10;
    localparam int K_II_DIV   = 100000;
    localparam int K_DRV_DIV  = 1000;
    localparam int K_T1_MUL   = 10000000;
    localparam int K_DEN_BASE = 79577;
    localparam int K_MS_SCALE = 10000;
    localparam int K_TGT_LIM  = 100;
    localparam int K_D_LIM    = 2000;
    localparam int K_LOW_SPD  = 50;

    // register reset values
    localparam int RST_LIM  = 2000;
    localparam int RST_BANK = 3000;

    typedef enum logic [2:0] {
        REG_OUTER_P   = 3'd0,
        REG_OUTER_I   = 3'd1,
        REG_INNER_P   = 3'd2,
        REG_INNER_I   = 3'd3,
        REG_INNER_D   = 3'd4,
        REG_OUTER_LIM = 3'd5,
        REG_INNER_LIM = 3'd6,
        REG_BANK      = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    // one multiply-divide operation per step of the update
    typedef enum logic [2:0] {
        OP_TGT,
        OP_OI,
        OP_PT,
        OP_II,
        OP_T1,
        OP_T2,
        OP_DRV
    } t_op;

    typedef struct packed {
        logic [GAIN_W-1:0] outer_p;
        logic [GAIN_W-1:0] outer_i;
        logic [GAIN_W-1:0] inner_p;
        logic [GAIN_W-1:0] inner_i;
        logic [GAIN_W-1:0] inner_d;
        logic [LIM_W-1:0]  outer_lim;
        logic [LIM_W-1:0]  inner_lim;
        logic [BANK_W-1:0] bank;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic div_start;
        logic wb;
        logic out_load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic ms_zero;
    } t_sts;

endpackage

`default_nettype wire

/* src/pcp_mul.sv */
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module pcp_mul import pcp_pkg::*; #(
    parameter int A_W = FD_W,
    parameter int B_W = MB_W,
    parameter int PR_W = P_W
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [A_W-1:0]  i_a,
    input  wire logic [B_W-1:0]  i_b,
    output logic      [PR_W-1:0] o_p,
    output logic                 o_done
);

    localparam int C_W = $clog2(B_W + 1);

    logic [PR_W-1:0] r_acc;
    logic [PR_W-1:0] r_a;
    logic [B_W-1:0]  r_b;
    logic [C_W-1:0]  r_cnt;
    logic            r_busy;
    logic            r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // accumulate partial products
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= PR_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_p    = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* src/pcp_div.sv */
`default_nettype none

// restoring divider, one quotient bit per cycle
module pcp_div import pcp_pkg::*; #(
    parameter int N_W = 65,
    parameter int D_W = DEN_W
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic      [N_W-1:0] o_q,
    output logic                o_done
);

    localparam int C_W = $clog2(N_W + 1);

    logic [N_W-1:0] r_q;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [D_W:0]   w_rs;
    logic [D_W:0]   w_diff;
    logic           w_ge;

    // trial subtract
    always_comb begin
        w_rs   = {r_rem, r_q[N_W-1]};
        w_diff = w_rs - {1'b0, r_den};
        w_ge   = (w_rs >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift dividend bits in, quotient bits out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_rs[D_W-1:0];
            r_q   <= {r_q[N_W-2:0], w_ge};
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* src/pcp_datapath.sv */
`default_nettype none

// operand selection, shared multiplier and divider, per-axis state
module pcp_datapath import pcp_pkg::*; #(
    parameter int AXES = AXES_DEF,
    parameter int FRAC = FRAC_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    input  wire t_cfg                     i_cfg,
    input  wire logic                     i_axis_select,
    input  wire logic signed [E_W-1:0]    i_position_error,
    input  wire logic signed [SPD_W-1:0]  i_measured_speed,
    input  wire logic [MS_W-1:0]          i_step_time_ms,
    output t_sts                          o_sts,
    output logic                          o_axis_out,
    output logic signed [TILT_W-1:0]      o_tilt_command
);

    localparam int AX_W  = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int INT_W = LIM_W + FRAC + 1;
    localparam int DIV_W = (FRAC + 49 > P_W) ? FRAC + 49 : P_W;
    localparam int QS_W  = DIV_W + 1;
    localparam int SUM_W = DIV_W + 3;
    localparam int WH_W  = LIM_W + 1;
    localparam int RS_W  = SPD_W + 3;
    localparam int PT_W  = 21;
    localparam int D_W   = 12;
    localparam int TG_W  = 8;
    localparam int NAV_W = 23;

    localparam logic signed [QS_W-1:0]  C_TGT_HI = QS_W'(K_TGT_LIM);
    localparam logic signed [QS_W-1:0]  C_D_HI   = QS_W'(K_D_LIM);
    localparam logic signed [RS_W-1:0]  C_R_HI   = RS_W'(32767);
    localparam logic signed [RS_W-1:0]  C_R_LO   = -RS_W'(32768);
    localparam logic signed [SUM_W-1:0] C_FD_HI  = SUM_W'({1'b0, {(FD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] C_FD_LO  = -C_FD_HI - SUM_W'(1);

    // item registers
    logic                     r_axis;
    logic [AX_W-1:0]          r_idx;
    logic signed [E_W-1:0]    r_e;
    logic signed [SPD_W-1:0]  r_spd;
    logic [MS_W-1:0]          r_ms;
    logic [2*MS_W-1:0]        r_io_ms;
    logic [2*MS_W-1:0]        r_ii_ms;
    logic [DEN_W-1:0]         r_ms_k;

    // intermediate results
    logic signed [TG_W-1:0]   r_target;
    logic signed [SPD_W-1:0]  r_r;
    logic signed [PT_W-1:0]   r_pterm;
    logic signed [QS_W-1:0]   r_t1;
    logic signed [D_W-1:0]    r_d;
    logic                     r_neg;
    logic                     r_axis_out;
    logic signed [TILT_W-1:0] r_tilt;

    // per-axis state
    logic signed [INT_W-1:0]  r_oi   [AXES];
    logic signed [INT_W-1:0]  r_ii   [AXES];
    logic signed [E_W-1:0]    r_prev [AXES];
    logic signed [FD_W-1:0]   r_fd   [AXES];

    logic signed [FD_W-1:0]   w_a;
    logic [FD_W-1:0]          w_a_mag;
    logic [MB_W-1:0]          w_b;
    logic [DEN_W-1:0]         w_dvsr;
    logic [DEN_W-1:0]         w_den;
    logic [P_W-1:0]           w_p;
    logic [P_W+FRAC-1:0]      w_shl;
    logic [DIV_W-1:0]         w_num;
    logic [DIV_W-1:0]         w_q;
    logic signed [QS_W-1:0]   w_qs;
    logic signed [WH_W-1:0]   w_oi_whole;
    logic signed [WH_W-1:0]   w_ii_whole;
    logic signed [RS_W-1:0]   w_r_sum;
    logic signed [SPD_W-1:0]  w_r;
    logic signed [E_W:0]      w_diff;
    logic signed [SUM_W-1:0]  w_oi_sum;
    logic signed [SUM_W-1:0]  w_ii_sum;
    logic signed [SUM_W-1:0]  w_fd_sum;
    logic signed [SUM_W-1:0]  w_olim;
    logic signed [SUM_W-1:0]  w_ilim;
    logic signed [SUM_W-1:0]  w_oi_cl;
    logic signed [SUM_W-1:0]  w_ii_cl;
    logic signed [SUM_W-1:0]  w_fd_cl;
    logic signed [TG_W-1:0]   w_target;
    logic signed [D_W-1:0]    w_d;
    logic signed [NAV_W-1:0]  w_nav_sum;
    logic signed [NAV_W-1:0]  w_bank;
    logic signed [NAV_W-1:0]  w_nav;
    logic                     w_low_spd;
    logic                     w_mul_done;
    logic                     w_div_done;

    // integer part of a fixed point value, rounded toward zero
    function automatic logic signed [WH_W-1:0] whole(input logic signed [INT_W-1:0] x);
        logic signed [INT_W-1:0] m;
        m = x[INT_W-1] ? -x : x;
        m = m >>> FRAC;
        return x[INT_W-1] ? -WH_W'(m) : WH_W'(m);
    endfunction

    // speed error and derivative input
    always_comb begin
        w_oi_whole = whole(r_oi[r_idx]);
        w_ii_whole = whole(r_ii[r_idx]);
        w_r_sum    = RS_W'(r_target) - RS_W'(r_spd) + RS_W'(w_oi_whole);
        if (w_r_sum > C_R_HI) begin
            w_r = SPD_W'(C_R_HI);
        end else if (w_r_sum < C_R_LO) begin
            w_r = SPD_W'(C_R_LO);
        end else begin
            w_r = SPD_W'(w_r_sum);
        end
        w_diff = (E_W+1)'(r_e) - (E_W+1)'(r_prev[r_idx]);
        w_den  = DEN_W'(K_DEN_BASE) + r_ms_k;
    end

    // operands of the current operation
    always_comb begin
        w_a    = '0;
        w_b    = '0;
        w_dvsr = '0;
        unique case (i_cmd.op)
            OP_TGT: begin
                w_a    = FD_W'(r_e);
                w_b    = MB_W'(i_cfg.outer_p);
                w_dvsr = DEN_W'(K_TGT_DIV);
            end
            OP_OI: begin
                w_a    = FD_W'(r_e);
                w_b    = MB_W'(r_io_ms);
                w_dvsr = DEN_W'(K_OI_DIV);
            end
            OP_PT: begin
                w_a    = FD_W'(w_r);
                w_b    = MB_W'(i_cfg.inner_p);
                w_dvsr = DEN_W'(K_PT_DIV);
            end
            OP_II: begin
                w_a    = FD_W'(r_r);
                w_b    = MB_W'(r_ii_ms);
                w_dvsr = DEN_W'(K_II_DIV);
            end
            OP_T1: begin
                w_a    = FD_W'(w_diff);
                w_b    = MB_W'(K_T1_MUL);
                w_dvsr = w_den;
            end
            OP_T2: begin
                w_a    = r_fd[r_idx];
                w_b    = MB_W'(r_ms_k);
                w_dvsr = w_den;
            end
            OP_DRV: begin
                w_a    = r_fd[r_idx];
                w_b    = MB_W'(i_cfg.inner_d);
                w_dvsr = DEN_W'(K_DRV_DIV);
            end
            default: begin
                w_a    = '0;
            end
        endcase
        w_a_mag = w_a[FD_W-1] ? FD_W'(-w_a) : FD_W'(w_a);
    end

    // dividend scaling
    always_comb begin
        w_shl = {w_p, {FRAC{1'b0}}};
        unique case (i_cmd.op)
            OP_OI, OP_II, OP_T1: w_num = w_shl[DIV_W-1:0];
            OP_DRV:              w_num = DIV_W'(w_p >> FRAC);
            default:             w_num = DIV_W'(w_p);
        endcase
        w_qs = r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    end

    pcp_mul #(
        .A_W (FD_W),
        .B_W (MB_W),
        .PR_W(P_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.mul_start),
        .i_a    (w_a_mag),
        .i_b    (w_b),
        .o_p    (w_p),
        .o_done (w_mul_done)
    );

    pcp_div #(
        .N_W(DIV_W),
        .D_W(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_dvsr),
        .o_q    (w_q),
        .o_done (w_div_done)
    );

    // integrator, filter and result clamps
    always_comb begin
        w_olim   = $signed(SUM_W'({i_cfg.outer_lim, {FRAC{1'b0}}}));
        w_ilim   = $signed(SUM_W'({i_cfg.inner_lim, {FRAC{1'b0}}}));
        w_oi_sum = SUM_W'(r_oi[r_idx]) + SUM_W'(w_qs);
        w_ii_sum = SUM_W'(r_ii[r_idx]) + SUM_W'(w_qs);
        w_fd_sum = SUM_W'(r_fd[r_idx]) + SUM_W'(r_t1) - SUM_W'(w_qs);

        if (w_oi_sum > w_olim) begin
            w_oi_cl = w_olim;
        end else if (w_oi_sum < -w_olim) begin
            w_oi_cl = -w_olim;
        end else begin
            w_oi_cl = w_oi_sum;
        end

        if (w_ii_sum > w_ilim) begin
            w_ii_cl = w_ilim;
        end else if (w_ii_sum < -w_ilim) begin
            w_ii_cl = -w_ilim;
        end else begin
            w_ii_cl = w_ii_sum;
        end

        if (w_fd_sum > C_FD_HI) begin
            w_fd_cl = C_FD_HI;
        end else if (w_fd_sum < C_FD_LO) begin
            w_fd_cl = C_FD_LO;
        end else begin
            w_fd_cl = w_fd_sum;
        end

        if (w_qs > C_TGT_HI) begin
            w_target = TG_W'(C_TGT_HI);
        end else if (w_qs < -C_TGT_HI) begin
            w_target = TG_W'(-C_TGT_HI);
        end else begin
            w_target = TG_W'(w_qs);
        end

        // derivative is dropped at low speed
        w_low_spd = (r_spd > -SPD_W'(K_LOW_SPD)) && (r_spd < SPD_W'(K_LOW_SPD));
        if (w_low_spd) begin
            w_d = '0;
        end else if (w_qs > C_D_HI) begin
            w_d = D_W'(C_D_HI);
        end else if (w_qs < -C_D_HI) begin
            w_d = D_W'(-C_D_HI);
        end else begin
            w_d = D_W'(w_qs);
        end

        // final tilt command
        w_nav_sum = NAV_W'(r_pterm) + NAV_W'(w_ii_whole) + NAV_W'(r_d);
        w_bank    = $signed(NAV_W'(i_cfg.bank));
        if (w_nav_sum > w_bank) begin
            w_nav = w_bank;
        end else if (w_nav_sum < -w_bank) begin
            w_nav = -w_bank;
        end else begin
            w_nav = w_nav_sum;
        end
    end

    // item capture and intermediate results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_axis  <= i_axis_select;
            r_idx   <= (AXES > 1) ? AX_W'(i_axis_select) : '0;
            r_e     <= i_position_error;
            r_spd   <= i_measured_speed;
            r_ms    <= i_step_time_ms;
            r_io_ms <= (2*MS_W)'(i_cfg.outer_i) * (2*MS_W)'(i_step_time_ms);
            r_ii_ms <= (2*MS_W)'(i_cfg.inner_i) * (2*MS_W)'(i_step_time_ms);
            r_ms_k  <= DEN_W'(i_step_time_ms * K_MS_SCALE);
        end
        if (i_cmd.mul_start) begin
            r_neg <= w_a[FD_W-1];
            if (i_cmd.op == OP_PT) begin
                r_r <= w_r;
            end
        end
        if (i_cmd.wb) begin
            if (i_cmd.op == OP_TGT) begin
                r_target <= w_target;
            end
            if (i_cmd.op == OP_PT) begin
                r_pterm <= w_qs[PT_W-1:0];
            end
            if (i_cmd.op == OP_T1) begin
                r_t1 <= w_qs;
            end
            if (i_cmd.op == OP_DRV) begin
                r_d <= w_d;
            end
        end
        if (i_cmd.out_load) begin
            r_axis_out <= r_axis;
            r_tilt     <= w_nav[TILT_W-1:0];
        end
    end

    // per-axis state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_oi[k]   <= '0;
                r_ii[k]   <= '0;
                r_prev[k] <= '0;
                r_fd[k]   <= '0;
            end
        end else if (i_cmd.wb) begin
            if (i_cmd.op == OP_OI) begin
                r_oi[r_idx] <= INT_W'(w_oi_cl);
            end
            if (i_cmd.op == OP_II) begin
                r_ii[r_idx] <= INT_W'(w_ii_cl);
            end
            if (i_cmd.op == OP_T2) begin
                r_fd[r_idx] <= FD_W'(w_fd_cl);
            end
            if (i_cmd.op == OP_DRV) begin
                r_prev[r_idx] <= r_e;
            end
        end
    end

    always_comb begin
        o_sts.mul_done = w_mul_done;
        o_sts.div_done = w_div_done;
        o_sts.ms_zero  = (r_ms == '0);
    end

    assign o_axis_out     = r_axis_out;
    assign o_tilt_command = r_tilt;

endmodule

`default_nettype wire

/* src/pcp_ctrl.sv */
`default_nettype none

// sequencer: walks the operations of one update and owns both handshakes
module pcp_ctrl import pcp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    n_op;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TGT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_stall = (r_state != S_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_TGT;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.wb = 1'b1;
                    n_state  = S_START;
                    unique case (r_op)
                        OP_TGT: n_op = OP_OI;
                        OP_OI:  n_op = OP_PT;
                        OP_PT:  n_op = OP_II;
                        // filter is held when the step time is zero
                        OP_II:  n_op = i_sts.ms_zero ? OP_DRV : OP_T1;
                        OP_T1:  n_op = OP_T2;
                        OP_T2:  n_op = OP_DRV;
                        OP_DRV: n_state = S_OUT;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* src/position_hold_cascade_pid.sv */
// Cascaded position-hold controller. Each request carries one axis update (axis, position
// error, measured speed, step time); the block returns one tilt command for that axis.
// An outer P+I loop on position error sets a speed target, an inner PI loop acts on the
// speed error, and a low-pass derivative of the position error is added before the bank
// limit clamp. One request is worked at a time: it runs through up to seven
// multiply-divide operations on a shared shift-add multiplier and a restoring
// divider of FRACTION_BITS + 49 quotient bits (at least 64); the filter operations
// are skipped when the step time is zero. The next request is taken while the
// previous command waits in the output register. Gains and limits are written
// through the APB port; the user must write them only while idle, as the block
// itself does not enforce it.
`default_nettype none

module position_hold_cascade_pid import pcp_pkg::*; #(
    parameter int AXES          = AXES_DEF,
    parameter int FRACTION_BITS = FRAC_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_axis_select,
    input  wire logic signed [E_W-1:0]    i_position_error,
    input  wire logic signed [SPD_W-1:0]  i_measured_speed,
    input  wire logic [MS_W-1:0]          i_step_time_ms,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_axis_out,
    output logic signed [TILT_W-1:0]      o_tilt_command
);

    t_cfg     r_cfg;
    t_cmd     w_cmd;
    t_sts     w_sts;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_p   <= '0;
            r_cfg.outer_i   <= '0;
            r_cfg.inner_p   <= '0;
            r_cfg.inner_i   <= '0;
            r_cfg.inner_d   <= '0;
            r_cfg.outer_lim <= LIM_W'(RST_LIM);
            r_cfg.inner_lim <= LIM_W'(RST_LIM);
            r_cfg.bank      <= BANK_W'(RST_BANK);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_OUTER_P:   r_cfg.outer_p   <= pwdata[GAIN_W-1:0];
                REG_OUTER_I:   r_cfg.outer_i   <= pwdata[GAIN_W-1:0];
                REG_INNER_P:   r_cfg.inner_p   <= pwdata[GAIN_W-1:0];
                REG_INNER_I:   r_cfg.inner_i   <= pwdata[GAIN_W-1:0];
                REG_INNER_D:   r_cfg.inner_d   <= pwdata[GAIN_W-1:0];
                REG_OUTER_LIM: r_cfg.outer_lim <= pwdata[LIM_W-1:0];
                REG_INNER_LIM: r_cfg.inner_lim <= pwdata[LIM_W-1:0];
                REG_BANK:      r_cfg.bank      <= pwdata[BANK_W-1:0];
                default:       r_cfg.bank      <= r_cfg.bank;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_idx)
            REG_OUTER_P:   prdata = DATA_W'(r_cfg.outer_p);
            REG_OUTER_I:   prdata = DATA_W'(r_cfg.outer_i);
            REG_INNER_P:   prdata = DATA_W'(r_cfg.inner_p);
            REG_INNER_I:   prdata = DATA_W'(r_cfg.inner_i);
            REG_INNER_D:   prdata = DATA_W'(r_cfg.inner_d);
            REG_OUTER_LIM: prdata = DATA_W'(r_cfg.outer_lim);
            REG_INNER_LIM: prdata = DATA_W'(r_cfg.inner_lim);
            REG_BANK:      prdata = DATA_W'(r_cfg.bank);
            default:       prdata = '0;
        endcase
    end

    pcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_cmd      (w_cmd)
    );

    pcp_datapath #(
        .AXES(AXES),
        .FRAC(FRACTION_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (r_cfg),
        .i_axis_select   (i_axis_select),
        .i_position_error(i_position_error),
        .i_measured_speed(i_measured_speed),
        .i_step_time_ms  (i_step_time_ms),
        .o_sts           (w_sts),
        .o_axis_out      (o_axis_out),
        .o_tilt_command  (o_tilt_command)
    );

endmodule

`default_nettype wire

/* src/pcp_checker.sv */
`default_nettype none

`include "position_hold_cascade_pid_macros.svh"

// port-level checks on the position-hold controller
module pcp_checker import pcp_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic                    o_axis_out,
    input wire logic signed [TILT_W-1:0] o_tilt_command
);

    // a held command keeps its payload
    `PCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_tilt_command) && $stable(o_axis_out))

    // an accepted request keeps the block busy on the next cycle
    `PCP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a new command only appears at the end of a worked request
    `PCP_ASSERT_NOW(a_out_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    // reset empties the output and frees the input
    `PCP_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind position_hold_cascade_pid pcp_checker u_pcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_axis_out    (o_axis_out),
    .o_tilt_command(o_tilt_command)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top import pcp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 5000000;
    localparam int  DRAIN_CYCLES = 1500;
    localparam int  PHASE_ITEMS  = 100;
    localparam int  PHASES       = 8;
    localparam longint ONE       = 64'sd1 << FRAC_DEF;
    localparam longint FD_HI     = (64'sd1 <<< 39) - 1;
    localparam longint FD_LO     = -(64'sd1 <<< 39);

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_axis_select;
    logic signed [E_W-1:0]    i_position_error;
    logic signed [SPD_W-1:0]  i_measured_speed;
    logic [MS_W-1:0]          i_step_time_ms;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic                     o_axis_out;
    logic signed [TILT_W-1:0] o_tilt_command;

    position_hold_cascade_pid dut (.*);

    // one expected tilt command
    typedef struct {
        logic                     axis;
        logic signed [TILT_W-1:0] tilt;
    } t_cmd_exp;

    // directed request row
    typedef struct {
        bit axis;
        int err;
        int spd;
        int ms;
        bit known;
        int tilt;
    } t_row;

    t_cmd_exp cmd_q[$];
    int       cycles;
    int       mismatches;
    bit       quiet;
    int       stall_hold;

    // controller copy: gains, limits and per-axis state
    longint g_op, g_oi, g_ip, g_ii, g_d, lim_o, lim_i, lim_bank;
    longint pos_int[2], spd_int[2], last_err[2], filt_d[2];

    // clock and cycle limit
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // trunc(p * one / den) toward zero
    function automatic longint frac_div(longint p, longint den);
        longint unsigned m;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned res;
        m   = p < 0 ? -p : p;
        q   = m / den;
        rem = m % den;
        res = (q << FRAC_DEF) + ((rem << FRAC_DEF) / den);
        return p < 0 ? -longint'(res) : longint'(res);
    endfunction

    function automatic void set_reg(t_reg_idx idx, longint v);
        case (idx)
            REG_OUTER_P:   g_op     = v & 8'hFF;
            REG_OUTER_I:   g_oi     = v & 8'hFF;
            REG_INNER_P:   g_ip     = v & 8'hFF;
            REG_INNER_I:   g_ii     = v & 8'hFF;
            REG_INNER_D:   g_d      = v & 8'hFF;
            REG_OUTER_LIM: lim_o    = v & 16'hFFFF;
            REG_INNER_LIM: lim_i    = v & 16'hFFFF;
            REG_BANK:      lim_bank = v & 14'h3FFF;
            default: ;
        endcase
    endfunction

    // cascaded update for one axis, returns the tilt command
    function automatic longint tilt_update(bit ax, longint e, longint spd, longint ms);
        longint tgt;
        longint lim;
        longint serr;
        longint pterm;
        longint iterm;
        longint den;
        longint t1;
        longint t2;
        longint dterm;
        tgt = clampl(e * g_op / 100, -100, 100);
        lim = lim_o * ONE;
        pos_int[ax] = clampl(pos_int[ax] + frac_div(e * g_oi * ms, 1000000), -lim, lim);
        serr = clampl(tgt - spd + pos_int[ax] / ONE, -32768, 32767);
        pterm = serr * g_ip / 10;
        lim = lim_i * ONE;
        spd_int[ax] = clampl(spd_int[ax] + frac_div(serr * g_ii * ms, 100000), -lim, lim);
        iterm = spd_int[ax] / ONE;
        if (ms != 0) begin
            den = 79577 + 10000 * ms;
            t1 = frac_div((e - last_err[ax]) * 10000000, den);
            t2 = filt_d[ax] * ms * 10000 / den;
            filt_d[ax] = clampl(filt_d[ax] + t1 - t2, FD_LO, FD_HI);
        end
        last_err[ax] = e;
        dterm = clampl(filt_d[ax] * g_d / (1000 * ONE), -2000, 2000);
        if (spd > -50 && spd < 50)
            dterm = 0;
        return clampl(pterm + iterm + dterm, -lim_bank, lim_bank);
    endfunction

    // apb write, setup then access
    task automatic reg_write(t_reg_idx idx, longint v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_reg(idx, v);
    endtask

    task automatic write_all(longint op, longint oi, longint ip, longint ii, longint d,
                             longint lo, longint li, longint bank);
        reg_write(REG_OUTER_P, op);
        reg_write(REG_OUTER_I, oi);
        reg_write(REG_INNER_P, ip);
        reg_write(REG_INNER_I, ii);
        reg_write(REG_INNER_D, d);
        reg_write(REG_OUTER_LIM, lo);
        reg_write(REG_INNER_LIM, li);
        reg_write(REG_BANK, bank);
    endtask

    // send one request and queue its expected command
    task automatic send_request(bit ax, int e, int spd, int ms, bit known, int tilt);
        t_cmd_exp x;
        longint   t;
        int       gap;
        i_in_valid       <= 1'b1;
        i_axis_select    <= ax;
        i_position_error <= E_W'(e);
        i_measured_speed <= SPD_W'(spd);
        i_step_time_ms   <= MS_W'(ms);
        do @(posedge i_clk); while (o_in_stall);
        t = tilt_update(ax, e, spd, ms);
        x.axis = ax;
        x.tilt = known ? TILT_W'(tilt) : TILT_W'(t);
        cmd_q.push_back(x);
        gap = 0;
        if (!quiet) begin
            gap = $urandom_range(0, 99);
            gap = gap < 55 ? 0 : (gap < 95 ? $urandom_range(1, 4) : $urandom_range(20, 400));
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (cmd_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic int rand_err();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed($urandom_range(0, 600)) - 300;
        else if (r < 75)
            return $signed($urandom_range(0, 40000)) - 20000;
        else if (r < 80)
            return r[0] ? 8388607 : -8388608;
        return $signed(24'($urandom));
    endfunction

    function automatic int rand_spd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $signed($urandom_range(0, 200)) - 100;
        else if (r < 85)
            return $signed($urandom_range(0, 3000)) - 1500;
        else if (r < 90)
            return r[0] ? 32767 : -32768;
        return $signed(16'($urandom));
    endfunction

    function automatic int rand_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 75)
            return $urandom_range(1, 30);
        return $urandom_range(0, 255);
    endfunction

    // output side stall pattern
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            stall_hold  <= stall_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2)
                stall_hold <= $urandom_range(20, 600);
            i_out_stall <= r < 30;
        end
    end

    // tilt command checker
    always @(posedge i_clk) begin
        t_cmd_exp x;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cmd_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected command axis=%0d tilt=%0d", o_axis_out,
                             o_tilt_command);
            end else begin
                x = cmd_q.pop_front();
                if (o_axis_out !== x.axis || o_tilt_command !== x.tilt) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("command mismatch: expected axis=%0d tilt=%0d, got axis=%0d tilt=%0d",
                                 x.axis, x.tilt, o_axis_out, o_tilt_command);
                end
            end
        end
    end

    // directed rows: extremes, zero step time, low speed edges, both axes
    t_row rows[14] = '{
        '{0, 0, 0, 0, 1, 0},
        '{1, 8388607, 32767, 255, 1, 0},
        '{0, -8388608, -32768, 255, 1, 0},
        '{1, -8388608, 49, 0, 1, 0},
        '{0, 8388607, -49, 1, 1, 0},
        '{1, 0, 50, 10, 1, 0},
        '{0, 100, -50, 0, 1, 0},
        '{1, -300, 200, 5, 1, 0},
        '{0, 300, -32768, 20, 1, 0},
        '{1, 5000, 32767, 255, 1, 0},
        '{0, -5000, 0, 1, 1, 0},
        '{1, 1, -1, 100, 1, 0},
        '{0, -1, 1, 0, 1, 0},
        '{1, 8388607, -32768, 3, 1, 0}
    };

    initial begin
        int ph;
        int k;
        cycles           = 0;
        mismatches       = 0;
        quiet            = 1'b0;
        stall_hold       = 0;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_out_stall      <= 1'b0;
        i_axis_select    <= 1'b0;
        i_position_error <= '0;
        i_measured_speed <= '0;
        i_step_time_ms   <= '0;
        g_op = 0; g_oi = 0; g_ip = 0; g_ii = 0; g_d = 0;
        lim_o = RST_LIM; lim_i = RST_LIM; lim_bank = RST_BANK;
        for (k = 0; k < 2; k++) begin
            pos_int[k] = 0; spd_int[k] = 0; last_err[k] = 0; filt_d[k] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains are zero, so every command is zero
        foreach (rows[k])
            send_request(rows[k].axis, rows[k].err, rows[k].spd, rows[k].ms,
                         rows[k].known, rows[k].tilt);
        drain();

        // same rows at full gains and widest limits
        write_all(255, 255, 255, 255, 255, 65535, 65535, 16383);
        foreach (rows[k])
            send_request(rows[k].axis, rows[k].err, rows[k].spd, rows[k].ms, 0, 0);
        drain();

        // random phases across several register settings
        for (ph = 0; ph < PHASES; ph++) begin
            quiet = (ph == 3);
            case (ph)
                0: write_all(255, 255, 255, 255, 255, 0, 0, 10000);
                1: write_all(0, 0, 0, 0, 0, 65535, 65535, 0);
                2: write_all(100, 20, 15, 10, 255, 300, 500, 16383);
                default: write_all($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 16383));
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
                send_request($urandom_range(0, 1), rand_err(), rand_spd(), rand_ms(), 0, 0);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && cmd_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
